[rtl/utf8sd_pkg.sv]
// Shared types, codes and tables for the UTF-8 stream decoder.
package utf8sd_pkg;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FORBIDDEN = 2'd1;
    localparam logic [1:0] ST_STRAY_END = 2'd2;
    localparam logic [1:0] ST_CUT       = 2'd3;

    localparam logic [31:0] SPACE_CODE = 32'd32;

    typedef struct packed {
        logic [2:0]  bytes_left;
        logic [2:0]  trail_total;
        logic [31:0] accumulator;
    } t_state;

    typedef struct packed {
        logic        emit;
        logic [31:0] code_point;
        logic [1:0]  status;
    } t_result;

    function automatic logic [31:0] trail_offset(input logic [2:0] trail);
        logic [31:0] off;
        begin
            case (trail)
                3'd1:    off = 32'h0000_3080;
                3'd2:    off = 32'h000E_2080;
                3'd3:    off = 32'h03C8_2080;
                3'd4:    off = 32'hFA08_2080;
                3'd5:    off = 32'h8208_2080;
                default: off = 32'h0000_0000;
            endcase
            return off;
        end
    endfunction

    function automatic logic [2:0] lead_trail_count(input logic [7:0] b);
        logic [2:0] n;
        begin
            if (b < 8'hE0)      n = 3'd1;
            else if (b < 8'hF0) n = 3'd2;
            else if (b < 8'hF8) n = 3'd3;
            else if (b < 8'hFC) n = 3'd4;
            else                n = 3'd5;
            return n;
        end
    endfunction

endpackage

[rtl/utf8sd_step.sv]
// Per-beat decode step: next state and optional result from state and byte.
module utf8sd_step
    import utf8sd_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_state     o_state,
    output t_result    o_result
);

    logic [31:0] lead_acc;
    logic [31:0] sum_acc;
    logic [31:0] shift_acc;
    logic [2:0]  lead_n;
    logic [2:0]  left_dec;

    assign lead_n    = lead_trail_count(i_byte);
    assign lead_acc  = {18'd0, i_byte, 6'd0};
    assign sum_acc   = i_state.accumulator + {24'd0, i_byte};
    assign shift_acc = {sum_acc[25:0], 6'd0};
    assign left_dec  = i_state.bytes_left - 3'd1;

    always_comb begin
        o_state  = i_state;
        o_result = '{emit: 1'b0, code_point: SPACE_CODE, status: ST_OK};
        if (i_state.bytes_left == 3'd0) begin
            if (i_byte[7] == 1'b0) begin
                o_result = '{emit: 1'b1, code_point: {24'd0, i_byte}, status: ST_OK};
            end else if (i_byte[6] == 1'b0) begin
                o_result = '{emit: i_last, code_point: SPACE_CODE, status: ST_STRAY_END};
            end else if (i_byte[7:1] == 7'h7F) begin
                o_result = '{emit: 1'b1, code_point: SPACE_CODE, status: ST_FORBIDDEN};
            end else if (i_last) begin
                o_state  = '0;
                o_result = '{emit: 1'b1, code_point: lead_acc - trail_offset(lead_n),
                             status: ST_CUT};
            end else begin
                o_state = '{bytes_left: lead_n, trail_total: lead_n, accumulator: lead_acc};
            end
        end else if (left_dec == 3'd0) begin
            o_state  = '0;
            o_result = '{emit: 1'b1, code_point: sum_acc - trail_offset(i_state.trail_total),
                         status: ST_OK};
        end else if (i_last) begin
            o_state  = '0;
            o_result = '{emit: 1'b1, code_point: shift_acc - trail_offset(i_state.trail_total),
                         status: ST_CUT};
        end else begin
            o_state.bytes_left  = left_dec;
            o_state.accumulator = shift_acc;
        end
    end

endmodule

[rtl/utf8_stream_decoder_unit.sv]
// Top level of the UTF-8 (six-byte form) stream decoder.
// One byte per beat, one beat per cycle while the output side does not stall: an
// input register feeds a single decode step (one 32-bit add, shift and offset
// subtract) that writes the result register, which drives the outputs.
// Bytes that finish nothing (leads, middle trailing bytes, stray continuation
// bytes, none of them at range end) give no result beat. Input stall rises
// only while both registers are full and the output side stalls.
module utf8_stream_decoder_unit
    import utf8sd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_range_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_code_point,
    output logic [1:0]  o_status
);

    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    t_state      r_state;
    t_state      n_state;
    t_result     n_result;
    logic        r_out_vld;
    logic [31:0] r_cp;
    logic [1:0]  r_st;
    logic        out_free;
    logic        proc;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign proc       = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;

    utf8sd_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (proc) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_vld <= proc && n_result.emit;
            end
        end
        if (!o_in_stall) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_range_end;
        end
        if (proc && n_result.emit) begin
            r_cp <= n_result.code_point;
            r_st <= n_result.status;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_code_point = r_cp;
    assign o_status     = r_st;

endmodule

[rtl/utf8sd_checker.sv]
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
module utf8sd_checker
    import utf8sd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [7:0]  i_data_byte,
    input logic        i_range_end,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_code_point,
    input logic [1:0]  o_status
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_out_valid) && $past(i_out_stall) && $past(i_rst_n)
        |-> o_out_valid && $stable(o_code_point) && $stable(o_status))
        else $error("result beat changed while stalled");

    // a stalled input beat holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_in_valid) && $past(o_in_stall) && $past(i_rst_n)
        |-> i_in_valid && $stable(i_data_byte) && $stable(i_range_end))
        else $error("input beat changed while stalled");

    // input backs up only behind a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // forbidden and stray-end results carry a space
    a_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FORBIDDEN || o_status == ST_STRAY_END)
        |-> o_code_point == SPACE_CODE)
        else $error("status without space code");

    // a fresh result beat follows an input beat taken through the input and result registers
    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !$past(o_out_valid)
        |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result beat without an input beat");

endmodule

bind utf8_stream_decoder_unit utf8sd_checker u_utf8sd_checker (.*);

[verif/utf8sd_checker.sv]
// Checker for the UTF-8 stream decoder: predicts decoded characters and compares result beats.
module utf8_decode_checker
    import utf8sd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_range_end,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_code_point,
    input  logic [1:0]  i_status,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0] code_point;
        logic [1:0]  status;
    } t_char;

    t_char       chars_due[$];
    t_char       want;
    logic [2:0]  seq_left;
    logic [2:0]  seq_trail;
    logic [31:0] seq_sum;

    function automatic logic [31:0] seq_offset(input logic [2:0] trail);
        case (trail)
            3'd1:    return 32'h0000_3080;
            3'd2:    return 32'h000E_2080;
            3'd3:    return 32'h03C8_2080;
            3'd4:    return 32'hFA08_2080;
            3'd5:    return 32'h8208_2080;
            default: return 32'h0;
        endcase
    endfunction

    function automatic logic [2:0] trail_bytes_for(input logic [7:0] lead);
        casez (lead)
            8'b110?_????: return 3'd1;
            8'b1110_????: return 3'd2;
            8'b1111_0???: return 3'd3;
            8'b1111_10??: return 3'd4;
            default:      return 3'd5;
        endcase
    endfunction

    function automatic void close_seq(input logic [1:0] st);
        chars_due.push_back('{code_point: seq_sum - seq_offset(seq_trail), status: st});
        seq_left  = '0;
        seq_trail = '0;
        seq_sum   = '0;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic at_end);
        if (seq_left == 3'd0) begin
            if (b <= 8'd127) begin
                chars_due.push_back('{code_point: {24'd0, b}, status: ST_OK});
            end else if (b[7:6] == 2'b10) begin
                if (at_end) begin
                    chars_due.push_back('{code_point: SPACE_CODE, status: ST_STRAY_END});
                end
            end else if (b[7:1] == 7'h7F) begin
                chars_due.push_back('{code_point: SPACE_CODE, status: ST_FORBIDDEN});
            end else begin
                seq_trail = trail_bytes_for(b);
                seq_left  = seq_trail;
                seq_sum   = {24'd0, b} << 6;
                if (at_end) begin
                    close_seq(ST_CUT);
                end
            end
        end else begin
            seq_sum  = seq_sum + {24'd0, b};
            seq_left = seq_left - 3'd1;
            if (seq_left == 3'd0) begin
                close_seq(ST_OK);
            end else begin
                seq_sum = seq_sum << 6;
                if (at_end) begin
                    close_seq(ST_CUT);
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("%0t: %s: got %h, want %h", $realtime, what, got, exp_val);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chars_due.delete();
            seq_left  = '0;
            seq_trail = '0;
            seq_sum   = '0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (chars_due.size() == 0) begin
                    report_mismatch("result beat with nothing due", i_code_point,
                                    {30'd0, i_status});
                end else begin
                    want = chars_due.pop_front();
                    if (i_code_point !== want.code_point) begin
                        report_mismatch("code_point", i_code_point, want.code_point);
                    end
                    if (i_status !== want.status) begin
                        report_mismatch("status", {30'd0, i_status}, {30'd0, want.status});
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                decode_byte(i_data_byte, i_range_end);
            end
        end
        o_pending = chars_due.size();
    end

endmodule

[verif/tb_utf8_stream_decoder_unit.sv]
// Testbench top for the UTF-8 stream decoder: clock, reset, byte stimulus and verdict.
module tb_utf8_stream_decoder_unit;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 80;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_range_end = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_code_point;
    logic [1:0]  o_status;

    int fail_count;
    int pending;
    int bytes_sent  = 0;
    int idle_run    = 0;
    int stall_left  = 0;
    int hold_left   = 0;
    bit hold_req    = 1'b0;
    bit hold_taken  = 1'b0;
    bit in_gaps_on  = 1'b1;
    bit out_gaps_on = 1'b1;

    utf8_stream_decoder_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_range_end  (i_range_end),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_code_point (o_code_point),
        .o_status     (o_status)
    );

    utf8_decode_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_range_end  (i_range_end),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_code_point (o_code_point),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int idle_len();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 70) return int'($urandom_range(1, 3));
        if (r < 93) return int'($urandom_range(4, 10));
        return int'($urandom_range(11, 40));
    endfunction

    // receiver: random stall bursts plus a long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                i_out_stall = 1'b1;
                stall_left--;
            end else begin
                i_out_stall = 1'b0;
                if (out_gaps_on && $urandom_range(0, 99) < 25) begin
                    stall_left = idle_len();
                end
            end
        end
    end

    initial begin
        do begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_run = 0;
            end else begin
                idle_run++;
            end
        end while (idle_run < IDLE_LIMIT);
        $display("utf8_stream_decoder_unit: mismatch");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic put_byte(input logic [7:0] b, input logic at_end);
        int gap;
        gap = 0;
        if (in_gaps_on && $urandom_range(0, 99) < 30) begin
            gap = idle_len();
        end
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_data_byte = b;
        i_range_end = at_end;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic put_sequence(input int n, input bit junk);
        int          cut_at;
        logic [7:0]  b;
        logic        at_end;
        cut_at = ($urandom_range(0, 99) < 8) ? int'($urandom_range(0, n - 1)) : -1;
        for (int i = 0; i <= n; i++) begin
            if (i == 0) begin
                case (n)
                    1:       b = 8'($urandom_range(8'hC0, 8'hDF));
                    2:       b = 8'($urandom_range(8'hE0, 8'hEF));
                    3:       b = 8'($urandom_range(8'hF0, 8'hF7));
                    4:       b = 8'($urandom_range(8'hF8, 8'hFB));
                    default: b = 8'($urandom_range(8'hFC, 8'hFD));
                endcase
            end else if (junk) begin
                b = 8'($urandom_range(0, 255));
            end else begin
                b = 8'($urandom_range(8'h80, 8'hBF));
            end
            at_end = (i == cut_at) || (i == n && $urandom_range(0, 5) == 0);
            put_byte(b, at_end);
            if (i == cut_at) break;
        end
    endtask

    task automatic put_random_text(input int target);
        int r;
        while (bytes_sent < target) begin
            r = int'($urandom_range(0, 99));
            if (r < 40) begin
                put_byte(8'($urandom_range(0, 127)), $urandom_range(0, 9) == 0);
            end else if (r < 75) begin
                put_sequence(int'($urandom_range(1, 5)), 1'b0);
            end else if (r < 85) begin
                put_sequence(int'($urandom_range(1, 5)), 1'b1);
            end else if (r < 90) begin
                put_byte(8'($urandom_range(8'h80, 8'hBF)), $urandom_range(0, 2) == 0);
            end else if (r < 95) begin
                put_byte(8'($urandom_range(8'hFE, 8'hFF)), 1'($urandom_range(0, 1)));
            end else begin
                put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // ASCII extremes, stray continuation, forbidden bytes
        put_byte(8'h00, 1'b0);
        put_byte(8'h7F, 1'b1);
        put_byte(8'h80, 1'b0);
        put_byte(8'hBF, 1'b1);
        put_byte(8'hFE, 1'b0);
        put_byte(8'hFF, 1'b1);
        // complete sequences of two, three, four and six bytes
        put_byte(8'hC0, 1'b0);
        put_byte(8'h80, 1'b0);
        put_byte(8'hE2, 1'b0);
        put_byte(8'h82, 1'b0);
        put_byte(8'hAC, 1'b0);
        put_byte(8'hF0, 1'b0);
        put_byte(8'h9F, 1'b0);
        put_byte(8'h98, 1'b0);
        put_byte(8'h80, 1'b1);
        put_byte(8'hFD, 1'b0);
        repeat (5) put_byte(8'hBF, 1'b0);
        // cut on the lead, cut after unchecked trailing bytes
        put_byte(8'hE2, 1'b1);
        put_byte(8'hF8, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h41, 1'b1);
        wait_drained();

        put_random_text(520);

        // long receiver hold-off while bytes keep coming
        in_gaps_on = 1'b0;
        hold_req   = 1'b1;
        repeat (30) put_byte(8'($urandom_range(0, 127)), 1'b0);
        wait_drained();

        out_gaps_on = 1'b0;
        put_random_text(1040);
        wait_drained();

        in_gaps_on  = 1'b1;
        out_gaps_on = 1'b1;
        put_random_text(1550);

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("utf8_stream_decoder_unit: match");
        end else begin
            $display("utf8_stream_decoder_unit: mismatch");
        end
        $finish;
    end

endmodule
